@@ rtl/core/fcc_pkg.sv @@
// Shared types, constants and the CRC step function of the frame checker.
`default_nettype none

package fcc_pkg;

  localparam int PAYLOAD_MAX = 31;
  localparam int IDX_W       = $clog2(PAYLOAD_MAX + 1);
  localparam int LEN_W       = 5;
  localparam int CNT_W       = 6;
  localparam int POS_W       = 7;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CNT_W-1:0] COUNT_MAX      = 6'd63;
  localparam logic [POS_W-1:0] FRAME_OVERHEAD = 7'd7;
  localparam logic [POS_W-1:0] PAYLOAD_START  = 7'd5;
  localparam logic [CNT_W-1:0] MIN_BYTES      = 6'd3;

  localparam logic [CNT_W-1:0] POS_HEAD0 = 6'd0;
  localparam logic [CNT_W-1:0] POS_HEAD1 = 6'd1;
  localparam logic [CNT_W-1:0] POS_INFO  = 6'd2;
  localparam logic [CNT_W-1:0] POS_CMD   = 6'd3;
  localparam logic [CNT_W-1:0] POS_SEQ   = 6'd4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  localparam logic [7:0] HEAD_FIRST_RST  = 8'hCA;
  localparam logic [7:0] HEAD_SECOND_RST = 8'hBD;

  localparam logic [CFG_IDX_W-1:0] REG_HEAD_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_SECOND = 1'b1;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic             item_kind;
    logic             frame_ok;
    logic [7:0]       command;
    logic [7:0]       sequence_res;
    logic [LEN_W-1:0] payload_len;
    logic [7:0]       payload_byte;
    logic             run_last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic byte_take;
    logic verdict_load;
    logic payload_load;
  } fcc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_ok;
    logic has_payload;
    logic last_item;
  } fcc_sts_t;

  // One byte through CRC-16/CCITT-FALSE, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/fcc_ctrl.sv @@
// Controller state machine: byte collection, verdict and payload replay sequencing.
`default_nettype none

module fcc_ctrl
  import fcc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_eob,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire fcc_sts_t sts,
  output fcc_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,
    ST_EVAL    = 3'b010,
    ST_REPLAY  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_COLLECT);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.byte_take    = 1'b0;
    cmd.verdict_load = 1'b0;
    cmd.payload_load = 1'b0;
    state_nxt        = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        cmd.byte_take = in_valid;
        if (in_valid && in_eob) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // hold the verdict until the output register frees up
        if (out_free) begin
          cmd.verdict_load = 1'b1;
          state_nxt = (sts.frame_ok && sts.has_payload) ? ST_REPLAY : ST_COLLECT;
        end
      end
      ST_REPLAY: begin
        if (out_free) begin
          cmd.payload_load = 1'b1;
          if (sts.last_item) begin
            state_nxt = ST_COLLECT;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.verdict_load || cmd.payload_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fcc_dpath.sv @@
// Datapath: header check, CRC accumulator, payload store and result register.
`default_nettype none

module fcc_dpath
  import fcc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire in_item_t             in_data,
  input  wire fcc_cmd_t             cmd,
  output fcc_sts_t                  sts,
  output out_item_t                 out_data
);

  logic [7:0]       head_first_r, head_second_r;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [15:0]      crc_acc_r, crc_acc_nxt;
  logic             header_bad_r, header_bad_nxt;
  logic [LEN_W-1:0] len_field_r, len_field_nxt;
  logic [7:0]       cmd_hold_r, cmd_hold_nxt;
  logic [7:0]       seq_hold_r, seq_hold_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;
  logic [7:0]       crc_hi_r, crc_hi_nxt;

  logic [7:0]       store [PAYLOAD_MAX];
  logic             st_we;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [7:0]       rd_data_r;

  out_item_t        out_r, out_nxt;

  logic [POS_W-1:0] pos_w, len_w, wr_off;
  logic [15:0]      crc_step;
  logic             ok;

  assign pos_w    = POS_W'(byte_count_r);
  assign len_w    = POS_W'(len_field_r);
  assign wr_off   = pos_w - PAYLOAD_START;
  assign wr_idx   = wr_off[IDX_W-1:0];
  assign crc_step = crc_feed(crc_acc_r, in_data.in_byte);

  // Per-byte frame parsing
  always_comb begin
    byte_count_nxt = byte_count_r;
    crc_acc_nxt    = crc_acc_r;
    header_bad_nxt = header_bad_r;
    len_field_nxt  = len_field_r;
    cmd_hold_nxt   = cmd_hold_r;
    seq_hold_nxt   = seq_hold_r;
    crc_lo_nxt     = crc_lo_r;
    crc_hi_nxt     = crc_hi_r;
    st_we          = 1'b0;
    if (cmd.verdict_load) begin
      byte_count_nxt = '0;
      crc_acc_nxt    = CRC_INIT;
      header_bad_nxt = 1'b0;
      len_field_nxt  = '0;
      cmd_hold_nxt   = '0;
      seq_hold_nxt   = '0;
      crc_lo_nxt     = '0;
      crc_hi_nxt     = '0;
    end else if (cmd.byte_take) begin
      if (byte_count_r == POS_HEAD0) begin
        if (in_data.in_byte != head_first_r) header_bad_nxt = 1'b1;
      end else if (byte_count_r == POS_HEAD1) begin
        if (in_data.in_byte != head_second_r) header_bad_nxt = 1'b1;
      end else if (byte_count_r == POS_INFO) begin
        len_field_nxt = in_data.in_byte[7:3];
        crc_acc_nxt   = crc_step;
      end else if (byte_count_r == POS_CMD) begin
        cmd_hold_nxt = in_data.in_byte;
        crc_acc_nxt  = crc_step;
      end else if (byte_count_r == POS_SEQ) begin
        seq_hold_nxt = in_data.in_byte;
        crc_acc_nxt  = crc_step;
      end else if (pos_w < PAYLOAD_START + len_w) begin
        st_we       = (wr_off < POS_W'(PAYLOAD_MAX));
        crc_acc_nxt = crc_step;
      end else if (pos_w == PAYLOAD_START + len_w) begin
        crc_lo_nxt = in_data.in_byte;
      end else if (pos_w == PAYLOAD_START + len_w + 7'd1) begin
        crc_hi_nxt = in_data.in_byte;
      end
      if (byte_count_r < COUNT_MAX) begin
        byte_count_nxt = byte_count_r + 6'd1;
      end
    end
  end

  assign ok = (byte_count_r >= MIN_BYTES)
           && (pos_w >= FRAME_OVERHEAD + len_w)
           && !header_bad_r
           && (len_w <= POS_W'(PAYLOAD_MAX))
           && (crc_acc_r == {crc_hi_r, crc_lo_r});

  assign sts.frame_ok    = ok;
  assign sts.has_payload = (len_field_r != '0);
  assign sts.last_item   = ((POS_W'(rd_idx_r) + 7'd1) == POS_W'(out_r.payload_len));

  // Replay read pointer: restart on verdict, advance per payload transfer
  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (cmd.verdict_load) begin
      rd_idx_nxt = '0;
    end else if (cmd.payload_load) begin
      rd_idx_nxt = rd_idx_r + IDX_W'(1);
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.verdict_load) begin
      out_nxt.item_kind    = KIND_VERDICT;
      out_nxt.frame_ok     = ok;
      out_nxt.command      = ok ? cmd_hold_r : 8'h00;
      out_nxt.sequence_res = ok ? seq_hold_r : 8'h00;
      out_nxt.payload_len  = ok ? len_field_r : '0;
      out_nxt.payload_byte = 8'h00;
      out_nxt.run_last     = !ok || (len_field_r == '0);
    end else if (cmd.payload_load) begin
      // command, sequence and length carry over from the verdict
      out_nxt.item_kind    = KIND_PAYLOAD;
      out_nxt.frame_ok     = 1'b1;
      out_nxt.payload_byte = rd_data_r;
      out_nxt.run_last     = sts.last_item;
    end
  end

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (st_we) begin
      store[wr_idx] <= in_data.in_byte;
    end
    if (POS_W'(rd_idx_nxt) < POS_W'(PAYLOAD_MAX)) begin
      rd_data_r <= store[rd_idx_nxt];
    end
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_first_r  <= HEAD_FIRST_RST;
      head_second_r <= HEAD_SECOND_RST;
      byte_count_r  <= '0;
      crc_acc_r     <= CRC_INIT;
      header_bad_r  <= 1'b0;
      len_field_r   <= '0;
      cmd_hold_r    <= '0;
      seq_hold_r    <= '0;
      crc_lo_r      <= '0;
      crc_hi_r      <= '0;
      rd_idx_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HEAD_FIRST:  head_first_r  <= cfg_data;
          REG_HEAD_SECOND: head_second_r <= cfg_data;
          default: ;
        endcase
      end
      byte_count_r <= byte_count_nxt;
      crc_acc_r    <= crc_acc_nxt;
      header_bad_r <= header_bad_nxt;
      len_field_r  <= len_field_nxt;
      cmd_hold_r   <= cmd_hold_nxt;
      seq_hold_r   <= seq_hold_nxt;
      crc_lo_r     <= crc_lo_nxt;
      crc_hi_r     <= crc_hi_nxt;
      rd_idx_r     <= rd_idx_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/frame_checker_crc16_unit.sv @@
// Frame checker top level: CRC-16 frame validation with payload replay.
// Bytes transfer in at one per cycle while a buffer is collected (CRC folds one byte a cycle).
// After the marked byte the controller evaluates the frame and, once the output register
// is free, loads the verdict into it; for a valid frame with payload, payload bytes then
// follow one per cycle from the payload store whenever the output register is free.
// Synchronous active-low reset restores header registers to 0xCA/0xBD and clears frame state.
`default_nettype none

module frame_checker_crc16_unit
  import fcc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  fcc_cmd_t cmd;
  fcc_sts_t sts;

  assign cfg_ready = 1'b1;

  fcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_eob    (in_data.end_of_buffer),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fcc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
